// ===== hdl/cssf_pkg.sv =====
// Shared constants and types for the cross stencil sharpen filter.
// No dependencies; imported by cross_stencil_sharpen_filter.
package cssf_pkg;

    localparam int MAX_LINE_ELEMENTS = 4096;
    localparam int MAX_ROWS          = 4096;

    // element and row positions, and line length / height that may equal the maximum
    localparam int ELEM_W = $clog2(MAX_LINE_ELEMENTS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int LEN_W  = $clog2(MAX_LINE_ELEMENTS + 1);
    localparam int HGT_W  = $clog2(MAX_ROWS + 1);

    localparam int SAMPLE_W   = 8;
    localparam int GAIN_W     = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CHAN_W     = 3;
    localparam int CFG_DATA_W = 13;
    localparam int PROD_W     = WIDTH_W + CHAN_W;

    // a 3-bit channel field can ask for up to seven components per pixel
    localparam int MAX_CHANNELS = (1 << CHAN_W) - 1;
    localparam int HIST_IDX_W   = $clog2(MAX_CHANNELS);

    localparam logic [GAIN_W-1:0]   GAIN_RESET     = GAIN_W'(5);
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET    = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = HEIGHT_W'(480);
    localparam logic [CHAN_W-1:0]   CHANNELS_RESET = CHAN_W'(3);

    localparam int MIN_EXTENT = 3;

    typedef enum logic [1:0] {
        CFG_GAIN     = 2'd0,
        CFG_WIDTH    = 2'd1,
        CFG_HEIGHT   = 2'd2,
        CFG_CHANNELS = 2'd3
    } cfg_index_t;

endpackage

// ===== hdl/cross_stencil_sharpen_filter.sv =====
// Cross stencil sharpen filter: line memories, position counters and the sharpen datapath.
// Depends on cssf_pkg.
//
// Takes one 8-bit component per clock of a channel-interleaved image in raster order and
// gives gain * centre minus its four same-channel cross neighbours, saturated to 0..255,
// with 0 on the outer rows and columns. The result for row r-1 leaves as the matching
// component of row r arrives, so the first row of a frame gives no words and the last row
// is never emitted. A new word is taken every clock while the output register is free or
// being read; the line memories are read as a word is taken, and the multiply and subtract
// run on the working stage, from which the word then moves into the output register. Two
// 4096 x 8 line memories hold the two rows above; they are not cleared after reset, so words
// of a row whose neighbours were never written are undefined.
// tuser on the input marks the first component of a frame and restarts the position count.
module cross_stencil_sharpen_filter (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [cssf_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] sample
    input  logic                             s_axis_tuser,  // [0] frame_start
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // [7:0] filtered
    output logic                             m_axis_tlast,  // row_end
    output logic                             m_axis_tuser   // [0] frame_end
);
    import cssf_pkg::*;

    // configuration
    logic [GAIN_W-1:0]   gain_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CHAN_W-1:0]   chan_reg;

    // effective geometry
    logic [CHAN_W-1:0]   chan_eff;
    logic [WIDTH_W-1:0]  width_eff;
    logic [PROD_W-1:0]   line_prod;
    logic [LEN_W-1:0]    line_len;
    logic [HGT_W-1:0]    frame_hgt;

    // position counters
    logic [ELEM_W-1:0]   elem_reg, elem_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ELEM_W-1:0]   e_pre, e_cur;
    logic [ROW_W-1:0]    r_pre, r_cur;
    logic [HGT_W-1:0]    r_wrap;
    logic [LEN_W-1:0]    e_inc;
    logic [HGT_W-1:0]    r_inc;
    logic [ELEM_W-1:0]   right_addr;

    // line memories
    logic [SAMPLE_W-1:0] upper_mem [MAX_LINE_ELEMENTS];
    logic [SAMPLE_W-1:0] middle_mem [MAX_LINE_ELEMENTS];

    // working stage
    logic                a_valid_reg;
    logic [SAMPLE_W-1:0] a_sample_reg;
    logic [ELEM_W-1:0]   a_elem_reg;
    logic [ROW_W-1:0]    a_row_reg;
    logic [SAMPLE_W-1:0] up_q_reg;
    logic [SAMPLE_W-1:0] mid_q_reg;
    logic [SAMPLE_W-1:0] right_q_reg;
    logic [SAMPLE_W-1:0] hist_reg [MAX_CHANNELS];

    logic                in_fire;
    logic                out_free;
    logic                a_prod;
    logic                a_go;
    logic                interior;
    logic [SAMPLE_W-1:0] left_val;
    logic [HIST_IDX_W-1:0] left_idx;
    logic [2*SAMPLE_W-1:0] centre_prod;
    logic [SAMPLE_W+1:0] nbr_sum;
    logic [2*SAMPLE_W:0] acc;
    logic [SAMPLE_W-1:0] sat_val;
    logic                row_end;
    logic                frame_end;

    // output register
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic                out_last_reg;
    logic                out_user_reg;

    // ------------------------------------------------------------------
    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            chan_reg   <= CHANNELS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GAIN:     gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_WIDTH:    width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT:   height_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_CHANNELS: chan_reg   <= cfg_data[CHAN_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        chan_eff  = (chan_reg == '0) ? CHAN_W'(1) : chan_reg;
        width_eff = (width_reg < WIDTH_W'(MIN_EXTENT)) ? WIDTH_W'(MIN_EXTENT) : width_reg;
        line_prod = PROD_W'(width_eff) * PROD_W'(chan_eff);
        line_len  = (line_prod > PROD_W'(MAX_LINE_ELEMENTS)) ? LEN_W'(MAX_LINE_ELEMENTS)
                                                             : LEN_W'(line_prod);
        if (height_reg < HEIGHT_W'(MIN_EXTENT))
            frame_hgt = HGT_W'(MIN_EXTENT);
        else if (height_reg > HEIGHT_W'(MAX_ROWS))
            frame_hgt = HGT_W'(MAX_ROWS);
        else
            frame_hgt = HGT_W'(height_reg);
    end

    // ------------------------------------------------------------------
    // position of the incoming word and of the one after it
    always_comb
    begin
        e_pre = s_axis_tuser ? '0 : elem_reg;
        r_pre = s_axis_tuser ? '0 : row_reg;
        // a counter beyond a shortened line or frame wraps
        if (LEN_W'(e_pre) >= line_len)
        begin
            e_cur  = '0;
            r_wrap = HGT_W'(r_pre) + HGT_W'(1);
        end
        else
        begin
            e_cur  = e_pre;
            r_wrap = HGT_W'(r_pre);
        end
        r_cur = (r_wrap >= frame_hgt) ? '0 : r_wrap[ROW_W-1:0];

        e_inc = LEN_W'(e_cur) + LEN_W'(1);
        r_inc = HGT_W'(r_cur) + HGT_W'(1);
        if (e_inc >= line_len)
        begin
            elem_next = '0;
            row_next  = (r_inc >= frame_hgt) ? '0 : r_inc[ROW_W-1:0];
        end
        else
        begin
            elem_next = e_inc[ELEM_W-1:0];
            row_next  = r_cur;
        end

        right_addr = ELEM_W'(LEN_W'(e_cur) + LEN_W'(chan_eff));
    end

    // ------------------------------------------------------------------
    // handshake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign a_prod        = (a_row_reg != '0);
    assign a_go          = a_valid_reg && (!a_prod || out_free);
    assign s_axis_tready = !a_valid_reg || a_go;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_reg    <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                elem_reg <= elem_next;
                row_reg  <= row_next;
            end
            if (in_fire)
                a_valid_reg <= 1'b1;
            else if (a_go)
                a_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // line memories: read as the word is taken, write as it leaves the working stage
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            up_q_reg    <= upper_mem[e_cur];
            mid_q_reg   <= middle_mem[e_cur];
            right_q_reg <= middle_mem[right_addr];
        end
        if (a_go)
        begin
            upper_mem[a_elem_reg]  <= mid_q_reg;
            middle_mem[a_elem_reg] <= a_sample_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_sample_reg <= s_axis_tdata[SAMPLE_W-1:0];
            a_elem_reg   <= e_cur;
            a_row_reg    <= r_cur;
        end
        // the left neighbour is the centre seen one pixel, i.e. chan_eff words, earlier
        if (a_go)
        begin
            hist_reg[0] <= mid_q_reg;
            for (int i = 1; i < MAX_CHANNELS; i++)
                hist_reg[i] <= hist_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // sharpen datapath
    always_comb
    begin
        left_idx    = HIST_IDX_W'(chan_eff - CHAN_W'(1));
        left_val    = hist_reg[left_idx];
        interior    = (a_row_reg >= ROW_W'(2))
                   && (LEN_W'(a_elem_reg) >= LEN_W'(chan_eff))
                   && ((LEN_W'(a_elem_reg) + LEN_W'(chan_eff)) < line_len);
        centre_prod = (2*SAMPLE_W)'(gain_reg) * (2*SAMPLE_W)'(mid_q_reg);
        nbr_sum     = (SAMPLE_W+2)'(up_q_reg) + (SAMPLE_W+2)'(right_q_reg)
                    + (SAMPLE_W+2)'(left_val) + (SAMPLE_W+2)'(a_sample_reg);
        acc         = (2*SAMPLE_W+1)'(centre_prod) - (2*SAMPLE_W+1)'(nbr_sum);
        // clamp to 0..255
        if (acc[2*SAMPLE_W])
            sat_val = '0;
        else if (acc[2*SAMPLE_W-1:SAMPLE_W] != '0)
            sat_val = '1;
        else
            sat_val = acc[SAMPLE_W-1:0];
        row_end   = (LEN_W'(a_elem_reg) == line_len - LEN_W'(1));
        frame_end = row_end && (HGT_W'(a_row_reg) == frame_hgt - HGT_W'(1));
    end

    // ------------------------------------------------------------------
    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (a_go && a_prod)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (a_go && a_prod)
        begin
            out_data_reg <= interior ? sat_val : '0;
            out_last_reg <= row_end;
            out_user_reg <= frame_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ===== sim/cross_stencil_sharpen_filter_checker.sv =====
// Scoreboard for the cross stencil sharpen filter: watches the register, input and output
// channels, predicts every filtered word and compares it field by field.
// Depends on cssf_pkg.
module cross_stencil_sharpen_filter_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [cssf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] sample
    input  logic                            s_axis_tuser,   // [0] frame_start
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [7:0]                      m_axis_tdata,   // [7:0] filtered
    input  logic                            m_axis_tlast,   // row_end
    input  logic                            m_axis_tuser,   // [0] frame_end
    output int                              words_pending,
    output int                              words_checked,
    output int                              mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import cssf_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered;
        logic                row_end;
        logic                frame_end;
    } sharpened_t;

    sharpened_t          expected_words[$];

    logic [GAIN_W-1:0]   gain_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CHAN_W-1:0]   channels_reg;

    // rows r-2 and r-1 relative to the row now arriving
    logic [SAMPLE_W-1:0] upper_row [MAX_LINE_ELEMENTS];
    logic [SAMPLE_W-1:0] middle_row [MAX_LINE_ELEMENTS];
    int unsigned         elem_at;
    int unsigned         row_at;
    int                  fail_total;
    int                  checked_total;

    function automatic int unsigned channel_stride();
        return (channels_reg == '0) ? 1 : int'(channels_reg);
    endfunction

    function automatic int unsigned line_elements();
        int unsigned n;
        n = (width_reg < MIN_EXTENT) ? MIN_EXTENT : int'(width_reg);
        n = n * channel_stride();
        return (n > MAX_LINE_ELEMENTS) ? MAX_LINE_ELEMENTS : n;
    endfunction

    function automatic int unsigned frame_rows();
        int unsigned n;
        n = (height_reg < MIN_EXTENT) ? MIN_EXTENT : int'(height_reg);
        return (n > MAX_ROWS) ? MAX_ROWS : n;
    endfunction

    function automatic void apply_register(input cfg_index_t idx,
                                           input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_GAIN:     gain_reg     = value[GAIN_W-1:0];
            CFG_WIDTH:    width_reg    = value[WIDTH_W-1:0];
            CFG_HEIGHT:   height_reg   = value[HEIGHT_W-1:0];
            CFG_CHANNELS: channels_reg = value[CHAN_W-1:0];
            default:      ;
        endcase
    endfunction

    // The arriving sample is the lower neighbour of the word leaving for the row above.
    function automatic void sharpen_sample(input logic [SAMPLE_W-1:0] arriving,
                                           input logic restart);
        int unsigned stride;
        int unsigned len;
        int unsigned rows;
        int unsigned e;
        int unsigned r;
        int          acc;
        sharpened_t  word;
        stride = channel_stride();
        len    = line_elements();
        rows   = frame_rows();
        if (restart)
        begin
            elem_at = 0;
            row_at  = 0;
        end
        // wrap counters left beyond a smaller line or frame
        if (elem_at >= len)
        begin
            elem_at = 0;
            row_at++;
        end
        if (row_at >= rows)
            row_at = 0;
        e = elem_at;
        r = row_at;
        if (r >= 1)
        begin
            acc = 0;
            if (r >= 2 && e >= stride && e + stride < len)
            begin
                // left neighbour has already been moved into the upper row
                acc = int'(gain_reg) * int'(middle_row[e])
                    - int'(upper_row[e - stride]) - int'(middle_row[e + stride])
                    - int'(upper_row[e]) - int'(arriving);
                if (acc < 0)
                    acc = 0;
                if (acc > 255)
                    acc = 255;
            end
            word.filtered  = acc[SAMPLE_W-1:0];
            word.row_end   = (e == len - 1);
            word.frame_end = (e == len - 1) && (r == rows - 1);
            expected_words.push_back(word);
        end
        upper_row[e]  = middle_row[e];
        middle_row[e] = arriving;
        elem_at = e + 1;
        if (elem_at >= len)
        begin
            elem_at = 0;
            row_at  = r + 1;
            if (row_at >= rows)
                row_at = 0;
        end
    endfunction

    function automatic void check_word(input logic [SAMPLE_W-1:0] filtered,
                                       input logic row_end, input logic frame_end);
        sharpened_t want;
        logic       bad;
        checked_total++;
        if (expected_words.size() == 0)
        begin
            $error("filtered word %0d arrived with no sample to account for it", filtered);
            fail_total++;
            return;
        end
        want = expected_words.pop_front();
        bad  = 1'b0;
        if (filtered !== want.filtered)
        begin
            $error("filtered: expected %0d, got %0d", want.filtered, filtered);
            bad = 1'b1;
        end
        if (row_end !== want.row_end)
        begin
            $error("row_end: expected %0b, got %0b", want.row_end, row_end);
            bad = 1'b1;
        end
        if (frame_end !== want.frame_end)
        begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
            bad = 1'b1;
        end
        if (bad)
            fail_total++;
    endfunction

    initial
    begin
        for (int i = 0; i < MAX_LINE_ELEMENTS; i++)
        begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        fail_total    = 0;
        checked_total = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     = GAIN_RESET;
            width_reg    = WIDTH_RESET;
            height_reg   = HEIGHT_RESET;
            channels_reg = CHANNELS_RESET;
            elem_at      = 0;
            row_at       = 0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index_t'(cfg_index), cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sharpen_sample(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
        words_pending  <= expected_words.size();
        words_checked  <= checked_total;
        mismatch_count <= fail_total;
    end

endmodule

// ===== sim/cross_stencil_sharpen_filter_test.sv =====
// Top of the cross stencil sharpen filter testbench: clock, reset, register writes and
// sample stimulus with random idling, and the final verdict.
// Depends on cssf_pkg, cross_stencil_sharpen_filter and cross_stencil_sharpen_filter_checker.
module cross_stencil_sharpen_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cssf_pkg::*;

    localparam int CLOCK_PERIOD   = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_SAMPLES = 1300;
    localparam int CORNER_SAMPLES = 150;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 16;
    // about 1750 samples, at up to 77 per cent idling on either side
    localparam int CYCLE_LIMIT    = 100000;

    typedef enum int {
        TEX_UNIFORM,
        TEX_SMOOTH,
        TEX_EXTREME
    } texture_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic [1:0]            cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic [7:0]            s_axis_tdata  = '0;   // [7:0] sample
    logic                  s_axis_tuser  = 1'b0; // [0] frame_start
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_ready;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [7:0]            m_axis_tdata;         // [7:0] filtered
    logic                  m_axis_tlast;         // row_end
    logic                  m_axis_tuser;         // [0] frame_end

    int                    words_pending;
    int                    words_checked;
    int                    mismatch_count;

    int unsigned           tx_idle_pct   = 10;
    int unsigned           rx_idle_pct   = 77;
    int unsigned           cycle_count   = 0;
    int unsigned           samples_sent  = 0;
    int unsigned           settings_used = 0;
    int unsigned           longest_line  = 0;
    int unsigned           tallest_frame = 0;
    int unsigned           cur_line;
    int unsigned           cur_rows;

    cross_stencil_sharpen_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    cross_stencil_sharpen_filter_checker sharpen_watch (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .m_axis_tuser   (m_axis_tuser),
        .words_pending  (words_pending),
        .words_checked  (words_checked),
        .mismatch_count (mismatch_count)
    );

    always #(CLOCK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d words outstanding", words_pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int unsigned line_length(input int unsigned w, input int unsigned c);
        int unsigned n;
        n = ((w < MIN_EXTENT) ? MIN_EXTENT : w) * ((c == 0) ? 1 : c);
        return (n > MAX_LINE_ELEMENTS) ? MAX_LINE_ELEMENTS : n;
    endfunction

    function automatic logic [7:0] pick_sample(input texture_t tex, input logic [7:0] base);
        case (tex)
            TEX_SMOOTH:  return base + 8'($urandom_range(16)) - 8'd8;
            TEX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
            default:     return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input int unsigned g, w, h, c);
        write_reg(CFG_GAIN, g);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_CHANNELS, c);
        cur_line = line_length(w, c);
        cur_rows = (h < MIN_EXTENT) ? MIN_EXTENT : ((h > MAX_ROWS) ? MAX_ROWS : h);
        settings_used++;
        if (cur_line > longest_line)
            longest_line = cur_line;
        if (cur_rows > tallest_frame)
            tallest_frame = cur_rows;
    endtask

    // Leaves tvalid high after the handshake; the next word's random idling or the idle wait lowers it.
    task automatic push_sample(input logic [7:0] value, input logic restart);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= restart;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        samples_sent++;
    endtask

    // Drain every outstanding word, then give the pipeline time to retire samples of a
    // first row, which leave no word behind.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic stream_run(input int unsigned n, input bit restart, input texture_t tex,
                              input bit noisy);
        logic [7:0] base;
        base = 8'($urandom_range(255));
        for (int unsigned i = 0; i < n; i++)
            push_sample(pick_sample(tex, base),
                        (i == 0 && restart) || (noisy && $urandom_range(299) == 0));
    endtask

    // 3 x 3 frame, listed in raster order
    task automatic stream_tile(input logic [8:0][7:0] tile, input bit restart);
        for (int i = 8; i >= 0; i--)
            push_sample(tile[i], restart && i == 8);
    endtask

    initial
    begin
        int unsigned start;
        int unsigned done;
        int unsigned g;
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned n;
        int unsigned cut;
        int unsigned frames;
        bit          restart;
        texture_t    tex;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a lone bright centre at full gain saturates high
        set_geometry(255, 3, 3, 1);
        stream_tile({8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1);
        // no gain and bright neighbours saturate low
        wait_idle();
        write_reg(CFG_GAIN, 0);
        stream_tile({9{8'd255}}, 1'b1);
        // unit gain, in range; run on from the frame end without a frame start
        wait_idle();
        write_reg(CFG_GAIN, 1);
        stream_tile({8'd10, 8'd20, 8'd30, 8'd40, 8'd250, 8'd60, 8'd70, 8'd80, 8'd90}, 1'b0);

        // shorten the line in row 0: the element count wraps into the border row
        wait_idle();
        set_geometry($urandom_range(255), 8, 10, 2);
        stream_run(12, 1'b1, TEX_UNIFORM, 1'b0);
        wait_idle();
        write_reg(CFG_WIDTH, 4);
        stream_run(8, 1'b0, TEX_UNIFORM, 1'b0);
        // lower the height under the current row: the row count wraps mid-line
        wait_idle();
        set_geometry($urandom_range(255), 3, 10, 1);
        stream_run(16, 1'b1, TEX_UNIFORM, 1'b0);
        wait_idle();
        write_reg(CFG_HEIGHT, 4);
        stream_run(5, 1'b0, TEX_UNIFORM, 1'b0);

        start = samples_sent;
        while (samples_sent - start < RANDOM_SAMPLES)
        begin
            done = samples_sent - start;
            if (done >= 2 * RANDOM_SAMPLES / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (done >= RANDOM_SAMPLES / 3)
            begin
                tx_idle_pct = 77;
                rx_idle_pct = 10;
            end
            wait_idle();
            case ($urandom_range(3))
                0:       g = $urandom_range(1) ? 255 : $urandom_range(1);
                1:       g = $urandom_range(255);
                default: g = $urandom_range(2, 8);
            endcase
            w = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
            c = ($urandom_range(5) == 0) ? $urandom_range(7) : $urandom_range(1, 4);
            h = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
            set_geometry(g, w, h, c);
            n = cur_line * cur_rows;
            frames  = $urandom_range(1, 3);
            restart = 1'b1;
            repeat (frames)
            begin
                tex = texture_t'($urandom_range(2));
                case ($urandom_range(9))
                    0:
                    begin
                        // cut the frame short; the next one must restart
                        cut = $urandom_range(1, n - 1);
                        stream_run(cut, restart, tex, 1'b1);
                        restart = 1'b1;
                    end
                    1:
                    begin
                        // change the gain mid-frame, keep the geometry
                        cut = $urandom_range(1, n - 1);
                        stream_run(cut, restart, tex, 1'b1);
                        wait_idle();
                        write_reg(CFG_GAIN, $urandom_range(255));
                        stream_run(n - cut, 1'b0, tex, 1'b1);
                        restart = $urandom_range(1);
                    end
                    default:
                    begin
                        stream_run(n, restart, tex, 1'b1);
                        restart = $urandom_range(1);
                    end
                endcase
            end
        end

        // longest line: 2047 pixels of 7 components saturate to the store depth;
        // run the start of the first row
        wait_idle();
        set_geometry($urandom_range(255), 2047, 3, 7);
        stream_run(CORNER_SAMPLES, 1'b1, TEX_UNIFORM, 1'b0);
        // tallest frame: 8191 rows saturate to the row limit; run the first fifty rows
        wait_idle();
        set_geometry($urandom_range(2, 8), 0, 8191, 0);
        stream_run(CORNER_SAMPLES, 1'b1, TEX_SMOOTH, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
        $display("Sent %0d samples over %0d image settings, lines up to %0d components",
                 samples_sent, settings_used, longest_line);
        $display("and frames up to %0d rows; %0d filtered words compared.",
                 tallest_frame, words_checked);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
